FILE: rtl/rcst_pkg.sv
`default_nettype none
package rcst_pkg;

  localparam int unsigned NUM_POSITIONS = 1024;
  localparam int unsigned LOG_POS       = 10;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned NODE_W        = 11;
  localparam int unsigned BOUND_W       = 12;
  localparam int unsigned LVL_W         = 4;
  localparam int unsigned HEIGHT_W      = 16;
  localparam int unsigned LEN_W         = 11;
  localparam int unsigned OP_W          = 2;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT  = 16'hFFFF;
  localparam logic [LEN_W-1:0]    LEN_RESET   = 11'd1024;
  localparam logic [LEN_W-1:0]    LEN_MAX     = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_RAISE = 2'd0,
    OP_LOWER = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Clamp map x -> min(max(x, lower), upper)
  typedef struct packed {
    logic [HEIGHT_W-1:0] lower;
    logic [HEIGHT_W-1:0] upper;
  } tag_t;

  localparam tag_t TAG_IDENT = '{lower: '0, upper: MAX_HEIGHT};
  localparam tag_t TAG_LEAF  = '{lower: '0, upper: '0};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_USE,
    ST_PS_PAR,
    ST_PS_C0,
    ST_PS_C1,
    ST_PS_W1,
    ST_PS_WP,
    ST_AP_SCAN,
    ST_AP_WRITE,
    ST_DONE
  } state_e;

  // Ancestor of a leaf at a given height above the leaf level
  function automatic logic [NODE_W-1:0] node_at(logic [POS_W-1:0] leaf,
                                                logic [LVL_W-1:0] lvl);
    logic [NODE_W-1:0] full;
    full = {1'b1, leaf};
    return full >> lvl;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rcst_in_if.sv
`default_nettype none
interface rcst_in_if;
  import rcst_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    range_start;
  logic [POS_W-1:0]    range_end;
  logic [HEIGHT_W-1:0] height;
  logic [POS_W-1:0]    position;

  modport source (output valid, operation, range_start, range_end, height, position,
                  input ready);
  modport sink   (input valid, operation, range_start, range_end, height, position,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/rcst_out_if.sv
`default_nettype none
interface rcst_out_if;
  import rcst_pkg::*;

  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] current_height;
  logic                range_error;

  modport source (output valid, current_height, range_error, input ready);
  modport sink   (input valid, current_height, range_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/rcst_cfg_if.sv
`default_nettype none
interface rcst_cfg_if;
  import rcst_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] wall_length;

  modport source (output valid, wall_length, input ready);
  modport sink   (input valid, wall_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/rcst_clamp_unit.sv
`default_nettype none
module rcst_clamp_unit
  import rcst_pkg::*;
(
  input  wire tag_t tag_i,
  input  wire tag_t bound_i,
  output tag_t      tag_o
);

  logic [HEIGHT_W-1:0] lo_max;
  logic [HEIGHT_W-1:0] up_max;

  // Compose outer map bound_i over inner map tag_i
  assign lo_max = (tag_i.lower < bound_i.lower) ? bound_i.lower : tag_i.lower;
  assign up_max = (tag_i.upper < bound_i.lower) ? bound_i.lower : tag_i.upper;

  assign tag_o.lower = (lo_max > bound_i.upper) ? bound_i.upper : lo_max;
  assign tag_o.upper = (up_max > bound_i.upper) ? bound_i.upper : up_max;

endmodule
`default_nettype wire

FILE: rtl/rcst_tag_ram.sv
`default_nettype none
module rcst_tag_ram
  import rcst_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [NODE_W-1:0] waddr_i,
  input  wire tag_t              wdata_i,
  input  wire logic [NODE_W-1:0] raddr_i,
  output tag_t                   rdata_o
);

  tag_t mem [2**NODE_W];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/range_clamp_segment_tree.sv
// Channel  Dir  Payload                                              Accept
// in_ch    in   operation, range_start, range_end, height, position  valid && ready
// out_ch   out  current_height, range_error                          valid && ready
// cfg_ch   in   wall_length                                          valid && ready
//
// After reset a clearing pass writes all 2048 tag entries, one per cycle; no item is
// accepted during it, configuration writes are taken. A read walks root to leaf
// over one shared clamp unit, reading then using each level. An update pushes tags
// on the two boundary paths (at most 19 nodes: parent and both children read, both
// children written, parent cleared), then applies the tag to the covering nodes
// (a scan and a write each, a scan per level step) via the single tag RAM port pair.
// One item at a time; the result register lets a new item in while a result waits.
`default_nettype none
module range_clamp_segment_tree
  import rcst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rcst_in_if.sink    in_ch,
  rcst_cfg_if.sink   cfg_ch,
  rcst_out_if.source out_ch
);

  state_e              state_q, state_d;
  logic [NODE_W-1:0]   clr_q, clr_d;
  logic [LEN_W-1:0]    wall_q;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic                side_q, side_d;
  logic [POS_W-1:0]    l_q, l_d, r_q, r_d, pos_q, pos_d;
  logic [HEIGHT_W-1:0] h_q, h_d;
  logic                raise_q, raise_d;
  tag_t                pt_q, pt_d, f_q, f_d;
  logic [BOUND_W-1:0]  cl_q, cl_d, cr_q, cr_d, cr_m1;
  logic [NODE_W-1:0]   ap_q, ap_d;
  logic [HEIGHT_W-1:0] res_h_q, res_h_d;
  logic                res_err_q, res_err_d;
  logic                out_valid_q, out_valid_d;
  logic [HEIGHT_W-1:0] out_h_q, out_h_d;
  logic                out_err_q, out_err_d;

  logic                wr_en;
  logic [NODE_W-1:0]   waddr, raddr;
  tag_t                wdata, rdata;
  tag_t                bound, clamp_out, op_bound;
  logic [LEN_W-1:0]    len;
  logic [NODE_W-1:0]   push_node;
  logic [NODE_W-1:0]   child0;
  logic                same_node;

  rcst_tag_ram u_ram (
    .clk_i   (clk_i),
    .wr_en_i (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rcst_clamp_unit u_clamp (
    .tag_i   (rdata),
    .bound_i (bound),
    .tag_o   (clamp_out)
  );

  assign len       = (wall_q > LEN_MAX) ? LEN_MAX : wall_q;
  assign push_node = node_at(side_q ? r_q : l_q, lvl_q);
  assign child0    = {push_node[NODE_W-2:0], 1'b0};
  assign same_node = (node_at(l_q, lvl_q) == node_at(r_q, lvl_q));
  assign cr_m1     = cr_q - BOUND_W'(1);
  assign op_bound  = raise_q ? '{lower: h_q, upper: MAX_HEIGHT}
                             : '{lower: '0, upper: h_q};

  // Pick the outer map for the shared clamp unit
  always_comb begin
    unique case (state_q)
      ST_RD_USE:   bound = f_q;
      ST_AP_WRITE: bound = op_bound;
      default:     bound = pt_q;
    endcase
  end

  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid          = out_valid_q;
  assign out_ch.current_height = out_h_q;
  assign out_ch.range_error    = out_err_q;

  // Sequencer: next state, RAM controls, datapath updates
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    side_d      = side_q;
    l_d         = l_q;
    r_d         = r_q;
    pos_d       = pos_q;
    h_d         = h_q;
    raise_d     = raise_q;
    pt_d        = pt_q;
    f_d         = f_q;
    cl_d        = cl_q;
    cr_d        = cr_q;
    ap_d        = ap_q;
    res_h_d     = res_h_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_h_d     = out_h_q;
    out_err_d   = out_err_q;
    wr_en       = 1'b0;
    waddr       = '0;
    wdata       = clamp_out;
    raddr       = '0;
    in_ch.ready = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        waddr = clr_q;
        wdata = clr_q[NODE_W-1] ? TAG_LEAF : TAG_IDENT;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          l_d       = in_ch.range_start;
          r_d       = in_ch.range_end;
          pos_d     = in_ch.position;
          h_d       = in_ch.height;
          raise_d   = (in_ch.operation == OP_RAISE);
          lvl_d     = LVL_W'(LOG_POS);
          side_d    = 1'b0;
          f_d       = TAG_IDENT;
          cl_d      = {2'b01, in_ch.range_start};
          cr_d      = {2'b01, in_ch.range_end} + BOUND_W'(1);
          res_h_d   = '0;
          res_err_d = 1'b0;
          unique case (in_ch.operation)
            OP_RAISE, OP_LOWER: begin
              if ((in_ch.range_start > in_ch.range_end) ||
                  ({1'b0, in_ch.range_end} >= len)) begin
                res_err_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                state_d   = ST_PS_PAR;
              end
            end
            OP_READ: begin
              if ({1'b0, in_ch.position} >= len) begin
                res_err_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                state_d   = ST_RD_REQ;
              end
            end
            default: begin
              res_err_d = 1'b1;
              state_d   = ST_DONE;
            end
          endcase
        end
      end

      // Walk root to leaf, composing ancestor maps
      ST_RD_REQ: begin
        raddr   = node_at(pos_q, lvl_q);
        state_d = ST_RD_USE;
      end

      ST_RD_USE: begin
        f_d = clamp_out;
        if (lvl_q == '0) begin
          res_h_d = clamp_out.upper;
          state_d = ST_DONE;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = ST_RD_REQ;
        end
      end

      // Push tags of one node into its children
      ST_PS_PAR: begin
        raddr   = push_node;
        state_d = ST_PS_C0;
      end

      ST_PS_C0: begin
        pt_d    = rdata;
        raddr   = child0;
        state_d = ST_PS_C1;
      end

      ST_PS_C1: begin
        wr_en   = 1'b1;
        waddr   = child0;
        raddr   = child0 | NODE_W'(1);
        state_d = ST_PS_W1;
      end

      ST_PS_W1: begin
        wr_en   = 1'b1;
        waddr   = child0 | NODE_W'(1);
        state_d = ST_PS_WP;
      end

      ST_PS_WP: begin
        wr_en = 1'b1;
        waddr = push_node;
        wdata = TAG_IDENT;
        if (!side_q && !same_node) begin
          side_d  = 1'b1;
          state_d = ST_PS_PAR;
        end else if (lvl_q == LVL_W'(1)) begin
          state_d = ST_AP_SCAN;
        end else begin
          side_d  = 1'b0;
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = ST_PS_PAR;
        end
      end

      // Climb the covering nodes bottom-up
      ST_AP_SCAN: begin
        if (cl_q >= cr_q) begin
          state_d = ST_DONE;
        end else if (cl_q[0]) begin
          raddr   = cl_q[NODE_W-1:0];
          ap_d    = cl_q[NODE_W-1:0];
          cl_d    = cl_q + BOUND_W'(1);
          state_d = ST_AP_WRITE;
        end else if (cr_q[0]) begin
          raddr   = cr_m1[NODE_W-1:0];
          ap_d    = cr_m1[NODE_W-1:0];
          cr_d    = cr_m1;
          state_d = ST_AP_WRITE;
        end else begin
          cl_d = cl_q >> 1;
          cr_d = cr_q >> 1;
        end
      end

      ST_AP_WRITE: begin
        wr_en   = 1'b1;
        waddr   = ap_q;
        state_d = ST_AP_SCAN;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_h_d     = res_h_q;
          out_err_d   = res_err_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wall_q      <= LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_ch.valid) begin
        wall_q <= cfg_ch.wall_length;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    side_q    <= side_d;
    l_q       <= l_d;
    r_q       <= r_d;
    pos_q     <= pos_d;
    h_q       <= h_d;
    raise_q   <= raise_d;
    pt_q      <= pt_d;
    f_q       <= f_d;
    cl_q      <= cl_d;
    cr_q      <= cr_d;
    ap_q      <= ap_d;
    res_h_q   <= res_h_d;
    res_err_q <= res_err_d;
    out_h_q   <= out_h_d;
    out_err_q <= out_err_d;
  end

  // Checks
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ch.ready)
    else $error("item taken during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready high right after an accepted item");

  a_error_zero_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.range_error) |-> (out_ch.current_height == '0))
    else $error("error result carries a height");

  a_no_root_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (state_q != ST_CLEAR)) |-> (waddr != '0))
    else $error("tag write to unused node zero");

endmodule
`default_nettype wire
